FILE: sv/crmt_pkg.sv
// ----------------------------------------------------------------------------
// crmt_pkg: shared types and constants for the consecutive range tracker
// Command/status structs between controller and datapath, result kinds and
// fixed field widths.
// ----------------------------------------------------------------------------
package crmt_pkg;

  localparam int DATA_W         = 32;  // value and window base width
  localparam int LEN_W          = 13;  // run_length / longest width
  localparam int EPOCH_BITS     = 8;   // presence tag width
  localparam int VALUE_BITS_DEF = 12;  // default window size exponent

  typedef enum logic [1:0] {
    RES_OK,
    RES_DUP,
    RES_OOW
  } res_kind_t;

  typedef struct packed {
    logic      load;     // capture input item
    logic      calc;     // register window offset, handle first flag
    logic      clr;      // one step of the presence tag sweep
    logic      rd_next;  // tag port A reads offset+1 instead of offset
    logic      chk;      // latch left neighbor presence
    logic      upd;      // mark present, resolve run ends
    logic      merge;    // write run ends, compute lengths
    logic      out_load; // load result register
    res_kind_t kind;     // result kind for out_load
  } cmd_t;

  typedef struct packed {
    logic in_win;      // value falls inside the window
    logic dup;         // value already present (valid in check step)
    logic clr_done;    // sweep at last entry
    logic epoch_full;  // epoch counter at its top value
    logic first;       // item starts a new data set
  } sts_t;

endpackage

FILE: sv/crmt_dpath.sv
// ----------------------------------------------------------------------------
// crmt_dpath: datapath of the consecutive range tracker
// Window offset, presence tag memory, run end memories, length and longest.
// ----------------------------------------------------------------------------
module crmt_dpath #(
  parameter int VALUE_BITS = crmt_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [crmt_pkg::DATA_W-1:0] cfg_wr_data,
  input  logic                        in_first,
  input  logic [crmt_pkg::DATA_W-1:0] in_value,
  input  crmt_pkg::cmd_t              cmd,
  output crmt_pkg::sts_t              sts,
  output logic [crmt_pkg::LEN_W-1:0]  res_run_length,
  output logic [crmt_pkg::LEN_W-1:0]  res_longest,
  output logic                        res_dup,
  output logic                        res_oow
);

  localparam int DEPTH  = 1 << VALUE_BITS;
  localparam int IDX_W  = VALUE_BITS;
  localparam int DW     = crmt_pkg::DATA_W;
  localparam int LEN_W  = crmt_pkg::LEN_W;
  localparam int EW     = crmt_pkg::EPOCH_BITS;
  localparam int SPAN_W = VALUE_BITS + 1;
  localparam int CMP_W  = (SPAN_W > LEN_W) ? SPAN_W : LEN_W;
  localparam logic [IDX_W-1:0] IDX_MAX   = {IDX_W{1'b1}};
  localparam logic [EW-1:0]    EPOCH_ONE = EW'(1);
  localparam logic [EW-1:0]    EPOCH_MAX = {EW{1'b1}};

  // control state
  logic [DW-1:0]    base_r;
  logic [EW-1:0]    epoch_r;
  logic [IDX_W-1:0] clr_cnt_r;
  logic [LEN_W-1:0] longest_r;

  // item payload
  logic             first_r;
  logic [DW-1:0]    value_r;
  logic [IDX_W-1:0] o_r;
  logic             left_r;
  logic [IDX_W-1:0] lo_r;
  logic [IDX_W-1:0] hi_r;
  logic [LEN_W-1:0] len_r;

  // memories and their read registers
  logic [EW-1:0]    tag_mem [DEPTH];
  logic [IDX_W-1:0] tab_mem [DEPTH];  // run top, stored at run bottom
  logic [IDX_W-1:0] bat_mem [DEPTH];  // run bottom, stored at run top
  logic [EW-1:0]    tag_qa_r;
  logic [EW-1:0]    tag_qb_r;
  logic [IDX_W-1:0] tab_q_r;
  logic [IDX_W-1:0] bat_q_r;

  logic signed [DW:0] off;
  logic [IDX_W-1:0]   o_up;
  logic [IDX_W-1:0]   o_dn;
  logic [IDX_W-1:0]   tag_ra;
  logic               tag_we;
  logic [IDX_W-1:0]   tag_wa;
  logic [EW-1:0]      tag_wd;
  logic               right;
  logic [IDX_W-1:0]   lo_nxt;
  logic [IDX_W-1:0]   hi_nxt;
  logic [SPAN_W-1:0]  span;

  // exact signed offset, one bit wider than the operands
  assign off  = $signed({value_r[DW-1], value_r}) - $signed({base_r[DW-1], base_r});
  assign o_up = o_r + 1'b1;
  assign o_dn = o_r - 1'b1;

  assign tag_ra = cmd.rd_next ? o_up : o_r;
  assign tag_we = cmd.clr | cmd.upd;
  assign tag_wa = cmd.clr ? clr_cnt_r : o_r;
  assign tag_wd = cmd.clr ? '0 : epoch_r;

  assign right  = (o_r != IDX_MAX) && (tag_qa_r == epoch_r);
  assign lo_nxt = left_r ? bat_q_r : o_r;
  assign hi_nxt = right ? tab_q_r : o_r;
  assign span   = (hi_r >= lo_r) ? ({1'b0, hi_r} - {1'b0, lo_r} + 1'b1) : SPAN_W'(1);

  assign sts.in_win     = (off[DW:IDX_W] == '0);
  assign sts.dup        = (tag_qa_r == epoch_r);
  assign sts.clr_done   = (clr_cnt_r == IDX_MAX);
  assign sts.epoch_full = (epoch_r == EPOCH_MAX);
  assign sts.first      = first_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    tag_qa_r <= tag_mem[tag_ra];
    tag_qb_r <= tag_mem[o_dn];
  end

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      tab_mem[lo_r] <= hi_r;
      bat_mem[hi_r] <= lo_r;
    end
    tab_q_r <= tab_mem[o_up];
    bat_q_r <= bat_mem[o_dn];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      epoch_r   <= EPOCH_ONE;
      clr_cnt_r <= '0;
      longest_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (cmd.calc && first_r) begin
        longest_r <= '0;
        if (epoch_r != EPOCH_MAX) begin
          epoch_r <= epoch_r + 1'b1;
        end
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == IDX_MAX) begin
          epoch_r <= EPOCH_ONE;
        end
      end
      if (cmd.merge && (CMP_W'(span) > CMP_W'(longest_r))) begin
        longest_r <= LEN_W'(span);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= in_first;
      value_r <= in_value;
    end
    if (cmd.calc) begin
      o_r <= off[IDX_W-1:0];
    end
    if (cmd.chk) begin
      left_r <= (o_r != '0) && (tag_qb_r == epoch_r);
    end
    if (cmd.upd) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (cmd.merge) begin
      len_r <= LEN_W'(span);
    end
    if (cmd.out_load) begin
      res_run_length <= (cmd.kind == crmt_pkg::RES_OK) ? len_r : '0;
      res_longest    <= longest_r;
      res_dup        <= (cmd.kind == crmt_pkg::RES_DUP);
      res_oow        <= (cmd.kind == crmt_pkg::RES_OOW);
    end
  end

endmodule

FILE: sv/crmt_ctrl.sv
// ----------------------------------------------------------------------------
// crmt_ctrl: controller of the consecutive range tracker
// Sequences tag sweeps, the per-item read/check/update/merge steps and the
// result register handshake.
// ----------------------------------------------------------------------------
module crmt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  crmt_pkg::sts_t sts,
  output crmt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CALC,
    ST_ITEM_CLR,
    ST_RD,
    ST_CHK,
    ST_UPD,
    ST_MERGE,
    ST_RESP
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  crmt_pkg::res_kind_t kind_r;
  crmt_pkg::res_kind_t kind_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.kind      = kind_r;
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_INIT_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (sts.first && sts.epoch_full) begin
          state_nxt = ST_ITEM_CLR;
        end else if (!sts.in_win) begin
          kind_nxt  = crmt_pkg::RES_OOW;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_ITEM_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          if (!sts.in_win) begin
            kind_nxt  = crmt_pkg::RES_OOW;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.chk     = 1'b1;
        cmd.rd_next = 1'b1;
        if (sts.dup) begin
          kind_nxt  = crmt_pkg::RES_DUP;
          state_nxt = ST_RESP;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        kind_nxt  = crmt_pkg::RES_OK;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (slot_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT_CLR;
      kind_r      <= crmt_pkg::RES_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/consecutive_range_merge_tracker.sv
// Steps: an in-window new value is loaded, then runs calc, read, check, update and
//   merge before the result loads; a repeated value skips update and merge, an
//   out-of-window value skips the rest after calc. One item is in flight at a time.
// A first flag bumps an 8-bit presence epoch; every 255th one adds a
//   sweep of all 2^VALUE_BITS tag memory entries before the item proceeds.
// Reset (rst_n low, synchronous): sweep of all 2^VALUE_BITS tag entries, in_tready low.
// ----------------------------------------------------------------------------
// consecutive_range_merge_tracker: tracks runs of consecutive values
// Values within a 2^VALUE_BITS window above window_base are marked present
// and merged with neighbor runs; each item returns its run length and the
// longest run of the current data set.
// ----------------------------------------------------------------------------
module consecutive_range_merge_tracker #(
  parameter int VALUE_BITS = crmt_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: window_base
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [0:0]  in_tuser,   // [0] first
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [12:0] run_length, [25:13] longest, [31:26] zero
  output logic [1:0]  out_tuser   // [0] duplicate, [1] out_of_window
);

  localparam int LEN_W = crmt_pkg::LEN_W;

  crmt_pkg::cmd_t   cmd;
  crmt_pkg::sts_t   sts;
  logic [LEN_W-1:0] res_run_length;
  logic [LEN_W-1:0] res_longest;
  logic             res_dup;
  logic             res_oow;

  // Controller: owns the handshake and step sequence.
  crmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: presence tags stamped with the data set epoch, so a new set
  // needs no clearing before epoch wrap; run ends kept at both ends of each run.
  crmt_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_first       (in_tuser[0]),
    .in_value       (in_tdata),
    .cmd            (cmd),
    .sts            (sts),
    .res_run_length (res_run_length),
    .res_longest    (res_longest),
    .res_dup        (res_dup),
    .res_oow        (res_oow)
  );

  assign out_tdata = {6'd0, res_longest, res_run_length};
  assign out_tuser = {res_oow, res_dup};

  // A result is never both repeated and out of window.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("duplicate and out_of_window both set");

  // An ignored value reports an empty run.
  a_ignored_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[0] || out_tuser[1])) |-> (out_tdata[12:0] == '0))
    else $error("ignored value with nonzero run_length");

  // A run can never be longer than the longest run reported with it.
  a_run_le_longest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:0] <= out_tdata[25:13]))
    else $error("run_length exceeds longest");

  // No new item enters while a result is still being produced.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

endmodule

FILE: bench/consecutive_range_merge_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// consecutive_range_merge_tracker_tb: self-checking bench for the run tracker
// Streams signed values through the block and checks each result against a
// cycle-free model of the run table (presence marks and run end pointers).
// Directed cases cover the window edges, exact offset math at the 32-bit
// limits, duplicates, two-sided merges and set clears. Random sets follow:
// shuffled blocks of consecutive values plus noise, several window bases,
// then many tiny sets to push the presence epoch through its wrap.
// ----------------------------------------------------------------------------
module consecutive_range_merge_tracker_tb;

  localparam int VB    = crmt_pkg::VALUE_BITS_DEF;
  localparam int WIN   = 1 << VB;
  localparam int LEN_W = crmt_pkg::LEN_W;

  // one input transfer
  typedef struct {
    logic        first;
    logic [31:0] value;
  } set_value_t;

  // one result transfer, as predicted
  typedef struct packed {
    logic [crmt_pkg::LEN_W-1:0] run_length;
    logic [crmt_pkg::LEN_W-1:0] longest;
    logic                       duplicate;
    logic                       out_of_window;
  } run_report_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;   // [31:0] value
  logic [0:0]  in_tuser    = '0;   // [0] first
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [12:0] run_length, [25:13] longest
  logic [1:0]  out_tuser;          // [0] duplicate, [1] out_of_window

  consecutive_range_merge_tracker #(
    .VALUE_BITS(VB)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Run table shadow: presence per window slot, and for each run its top
  // stored at the bottom slot and its bottom stored at the top slot.
  // --------------------------------------------------------------------------
  logic signed [31:0]         win_base = '0;
  bit                         present [WIN];
  bit [VB-1:0]                top_of_run [WIN];
  bit [VB-1:0]                bottom_of_run [WIN];
  bit [crmt_pkg::LEN_W-1:0]   best_len = '0;

  set_value_t  value_q [$];   // values waiting to be sent
  run_report_t report_q [$];  // results owed by the block, oldest first
  int unsigned pushed     = 0;
  int unsigned mismatches = 0;

  function automatic run_report_t track_value(logic first, logic signed [31:0] value);
    longint      off;
    int unsigned o, lo, hi;
    run_report_t r;
    r = '0;
    if (first) begin
      present  = '{default: 1'b0};
      best_len = '0;
    end
    // offset is taken at full precision, so no wrap at the 32-bit limits
    off = longint'(value) - longint'(win_base);
    if (off < 0 || off >= longint'(WIN)) begin
      r.longest       = best_len;
      r.out_of_window = 1'b1;
      return r;
    end
    o = int'(off);
    if (present[o]) begin
      r.longest   = best_len;
      r.duplicate = 1'b1;
      return r;
    end
    // neighbors past either window edge count as absent
    lo = (o > 0 && present[o-1]) ? int'(bottom_of_run[o-1]) : o;
    hi = (o + 1 < WIN && present[o+1]) ? int'(top_of_run[o+1]) : o;
    present[o]        = 1'b1;
    top_of_run[lo]    = VB'(hi);
    bottom_of_run[hi] = VB'(lo);
    r.run_length = LEN_W'(hi - lo + 1);
    if (r.run_length > best_len) best_len = r.run_length;
    r.longest = best_len;
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Sampling at the rising edge: input transfers feed the predictor, result
  // transfers are checked field by field against the oldest expectation.
  // --------------------------------------------------------------------------
  logic        in_xfer = 1'b0;
  run_report_t head;

  always @(posedge clk) begin
    in_xfer <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        note_mismatch("unexpected result", 32'd0, out_tdata);
      end else begin
        head = report_q.pop_front();
        if (out_tdata[12:0] !== head.run_length)
          note_mismatch("run_length", 32'(head.run_length), 32'(out_tdata[12:0]));
        if (out_tdata[25:13] !== head.longest)
          note_mismatch("longest", 32'(head.longest), 32'(out_tdata[25:13]));
        if (out_tuser[0] !== head.duplicate)
          note_mismatch("duplicate", 32'(head.duplicate), 32'(out_tuser[0]));
        if (out_tuser[1] !== head.out_of_window)
          note_mismatch("out_of_window", 32'(head.out_of_window), 32'(out_tuser[1]));
      end
    end
    if (rst_n && in_tvalid && in_tready)
      report_q.push_back(track_value(in_tuser[0], in_tdata));
  end

  // --------------------------------------------------------------------------
  // Sender: bursts of random length separated by random gaps (often none).
  // A new value goes out only once the previous one has made its transfer.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  set_value_t  next_value;

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_xfer)) begin
      if (gap_left != 0 || value_q.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        next_value = value_q.pop_front();
        in_tdata  <= next_value.value;
        in_tuser  <= next_value.first;
        in_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: on each countdown end picks a stall style - always ready, coin flip,
  // a rotating random pattern, or a long stall followed by a ready stretch.
  // --------------------------------------------------------------------------
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;
  logic [31:0] stall_pat  = '1;

  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      stall_pat  = $urandom;
      ready_left = 32;
    end
    ready_left--;
    case (ready_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_tready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[31:1]};
      end
      default: begin
        out_tready <= (ready_left < 12);
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push(logic first, logic [31:0] value);
    set_value_t s;
    s.first = first;
    s.value = value;
    value_q.push_back(s);
    pushed++;
  endtask

  // block goes quiet: nothing queued, nothing in flight
  task automatic settle();
    while (value_q.size() != 0 || in_tvalid || report_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_base(logic [31:0] b);
    settle();
    cfg_wr_data <= b;
    cfg_wr_en   <= 1'b1;
    win_base     = b;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // window base anywhere that still leaves the full window representable
  function automatic logic [31:0] random_base();
    logic signed [31:0] b;
    b = $urandom;
    if (b > 32'sh7FFF_F000) b = 32'sh7FFF_F000;
    return b;
  endfunction

  // One data set: a block of consecutive offsets, either sent as a shuffled
  // permutation (with repeats at the tail) or as random picks from the block,
  // sprinkled with edge and full-range noise.
  task automatic add_random_set();
    int unsigned span, start, count, k, j, tmp, pick;
    int unsigned order [$];
    bit          shuffled, first;
    logic [31:0] v;
    span = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 160) : $urandom_range(2, 24);
    case ($urandom_range(0, 5))
      0: start = 0;
      1: start = WIN - span;
      default: start = $urandom_range(0, WIN - span);
    endcase
    for (k = 0; k < span; k++) order.push_back(start + k);
    for (k = span - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    shuffled = ($urandom_range(0, 1) == 1);
    count    = shuffled ? span + $urandom_range(0, 3) : $urandom_range(1, 30);
    first    = ($urandom_range(0, 9) != 0);  // sometimes keep the previous set
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      v = $urandom;
      else if (pick == 1) v = win_base - 1;
      else if (pick == 2) v = win_base + WIN;
      else if (shuffled)  v = win_base + order[k % span];
      else                v = win_base + start + $urandom_range(0, span - 1);
      push(first && k == 0, v);
    end
  endtask

  initial begin : stimulus
    int unsigned phase, target, off;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // base zero: edges, merges from each side and both, repeats, clears
    write_base(32'h0000_0000);
    push(1'b1, 32'd0);            // bottom edge, left neighbor off window
    push(1'b0, WIN - 1);          // top edge, right neighbor off window
    push(1'b0, WIN - 2);          // joins run above
    push(1'b0, 32'd2);
    push(1'b0, 32'd1);            // bridges 0 and 2
    push(1'b0, 32'd1);            // repeat
    push(1'b0, WIN);              // one past the top
    push(1'b0, 32'hFFFF_FFFF);    // one below the bottom
    push(1'b0, 32'h8000_0000);
    push(1'b0, 32'h7FFF_FFFF);
    push(1'b0, WIN - 3);
    push(1'b0, 32'd10);
    push(1'b0, 32'd12);
    push(1'b0, 32'd11);           // two-sided merge
    push(1'b1, WIN);              // clear on an off-window value
    push(1'b0, 32'd0);            // must be fresh after the clear

    // lowest base: window hugs the negative limit
    write_base(32'h8000_0000);
    push(1'b1, 32'h8000_0000);
    push(1'b0, 32'h8000_0000 + WIN - 1);
    push(1'b0, 32'h8000_0000 + WIN);
    push(1'b0, 32'h7FFF_FFFF);
    push(1'b0, 32'h8000_0001);

    // highest base: a single reachable slot, no wrap into negative values
    write_base(32'h7FFF_FFFF);
    push(1'b1, 32'h7FFF_FFFF);
    push(1'b0, 32'h8000_0000);
    push(1'b0, 32'h7FFF_FFFE);
    push(1'b0, 32'h7FFF_FFFF);

    // random sets under several bases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_base(32'h7FFF_F000);
        1: write_base(-32'sd2048);
        default: write_base(random_base());
      endcase
      target = pushed + 20;
      while (pushed < target) add_random_set();
    end

    // many tiny sets: drives the presence epoch through its wrap and sweep,
    // and any stale mark would show up as a bogus repeat or merge
    write_base(random_base());
    repeat (256) begin
      off = $urandom_range(0, 7);
      push(1'b1, win_base + off);
      case ($urandom_range(0, 11))
        0: push(1'b0, win_base + off + 1);
        1: push(1'b0, win_base + off - 1);
        2: push(1'b0, win_base + off);
        default: ;
      endcase
    end

    settle();
    if (mismatches == 0) begin
      $display("consecutive_range_merge_tracker test passed");
    end else begin
      $display("consecutive_range_merge_tracker test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run including reset and epoch sweeps
  initial begin
    #1000000;
    $display("consecutive_range_merge_tracker test failed");
    $finish;
  end

endmodule
